// ===== sv/sap_pkg.sv =====
`timescale 1ns / 1ps
package sap_pkg;

   localparam int MAX_ATLASES = 8;
   localparam int IDX_W       = (MAX_ATLASES > 1) ? $clog2(MAX_ATLASES) : 1;
   localparam int COUNT_W     = $clog2(MAX_ATLASES + 1);

   localparam logic [12:0] RST_ATLAS_WIDTH  = 13'd512;
   localparam logic [12:0] RST_ATLAS_HEIGHT = 13'd512;
   localparam logic [2:0]  RST_PAD_PIXELS   = 3'd1;
   localparam logic [11:0] SIZE_MAX12       = 12'hFFF;

   localparam logic [1:0] CSR_ATLAS_WIDTH  = 2'd0;
   localparam logic [1:0] CSR_ATLAS_HEIGHT = 2'd1;
   localparam logic [1:0] CSR_PAD_PIXELS   = 2'd2;

   typedef struct packed {
      logic [12:0] width;
      logic [12:0] height;
      logic [2:0]  pad;
   } cfg_type;

   // sized glyph handed from the front to the back
   typedef struct packed {
      logic        zero;
      logic [11:0] sw;
      logic [11:0] sh;
      logic [12:0] wp;
      logic [12:0] hp;
   } q_item_type;

   typedef struct packed {
      logic        full;
      logic        opened;
      logic [11:0] sh;
      logic [11:0] sw;
      logic [11:0] pos_y;
      logic [11:0] pos_x;
      logic [2:0]  atlas_index;
      logic        placed;
   } rsp_item_type;

   function automatic logic [11:0] sat12(input logic [12:0] v);
      logic [11:0] r;
      r = (v > 13'(SIZE_MAX12)) ? SIZE_MAX12 : v[11:0];
      return r;
   endfunction

endpackage

// ===== sv/shelf_atlas_packer.sv =====
`timescale 1ns / 1ps
// Path: front product register, two-item queue, back end scan state, result register.
// The back end tests one atlas per cycle while scanning, holding while the result register
// is stalled; the two-item queue decouples front and back, so requests are taken during a scan.
// Reset: synchronous, active high; registers return to 512 x 512 atlases with
// one pixel of padding, atlas 0 open and every cursor and row at zero.
module shelf_atlas_packer
   import sap_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // glyph_width, glyph_height, scale_q10
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,   // placed, atlas_index, pos_x, pos_y, scaled_width,
                                    // scaled_height, opened_atlas, atlases_full
   input  logic        csr_wen,
   input  logic [1:0]  csr_addr,
   input  logic [12:0] csr_wdata
);

   cfg_type      cfg_ff;
   logic         q_push;
   q_item_type   q_push_item;
   logic         q_full;
   logic         q_pop;
   logic         q_valid;
   q_item_type   q_head;
   rsp_item_type rsp_item;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.width  <= RST_ATLAS_WIDTH;
         cfg_ff.height <= RST_ATLAS_HEIGHT;
         cfg_ff.pad    <= RST_PAD_PIXELS;
      end else if (csr_wen) begin
         unique case (csr_addr)
            CSR_ATLAS_WIDTH:  cfg_ff.width  <= csr_wdata;
            CSR_ATLAS_HEIGHT: cfg_ff.height <= csr_wdata;
            CSR_PAD_PIXELS:   cfg_ff.pad    <= csr_wdata[2:0];
            default: ;
         endcase
      end
   end

   sap_front u_front (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (req_tvalid),
      .in_ready     (req_tready),
      .glyph_width  (req_tdata[10:0]),
      .glyph_height (req_tdata[21:11]),
      .scale_q10    (req_tdata[37:22]),
      .cfg          (cfg_ff),
      .push         (q_push),
      .push_item    (q_push_item),
      .q_full       (q_full)
   );

   sap_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (q_push_item),
      .full      (q_full),
      .pop       (q_pop),
      .valid     (q_valid),
      .head      (q_head)
   );

   sap_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .q_valid   (q_valid),
      .q_head    (q_head),
      .pop       (q_pop),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_item  (rsp_item)
   );

   assign rsp_tdata = {2'b00, rsp_item};

endmodule

// ===== sv/sap_queue.sv =====
`timescale 1ns / 1ps
module sap_queue
   import sap_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  q_item_type push_item,
   output logic       full,
   input  logic       pop,
   output logic       valid,
   output q_item_type head
);

   q_item_type  mem_ff [2];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  count_ff, count_in;
   logic        do_push, do_pop;

   assign full    = (count_ff == 2'd2);
   assign valid   = (count_ff != 2'd0);
   assign head    = mem_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && valid;

   always_comb begin
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ===== sv/sap_front.sv =====
`timescale 1ns / 1ps
module sap_front
   import sap_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   output logic        in_ready,
   input  logic [10:0] glyph_width,
   input  logic [10:0] glyph_height,
   input  logic [15:0] scale_q10,
   input  cfg_type     cfg,
   output logic        push,
   output q_item_type  push_item,
   input  logic        q_full
);

   logic        s1_valid_ff, s1_valid_in;
   logic [26:0] prod_w_ff;
   logic [26:0] prod_h_ff;
   logic        zero_ff;
   logic [27:0] ceil_w;
   logic [27:0] ceil_h;
   logic [16:0] sw_full;
   logic [16:0] sh_full;
   logic [11:0] sw;
   logic [11:0] sh;
   logic [12:0] pad2;

   assign push     = s1_valid_ff && !q_full;
   assign in_ready = !s1_valid_ff || push;

   always_comb begin
      ceil_w  = {1'b0, prod_w_ff} + 28'd1023;
      ceil_h  = {1'b0, prod_h_ff} + 28'd1023;
      sw_full = ceil_w[26:10];
      sh_full = ceil_h[26:10];
      sw      = (sw_full > 17'(SIZE_MAX12)) ? SIZE_MAX12 : sw_full[11:0];
      sh      = (sh_full > 17'(SIZE_MAX12)) ? SIZE_MAX12 : sh_full[11:0];
      pad2    = {9'd0, cfg.pad, 1'b0};
      push_item.zero = zero_ff;
      push_item.sw   = sw;
      push_item.sh   = sh;
      push_item.wp   = {1'b0, sw} + pad2;
      push_item.hp   = {1'b0, sh} + pad2;
      s1_valid_in    = in_ready ? in_valid : s1_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         prod_w_ff <= glyph_width * scale_q10;
         prod_h_ff <= glyph_height * scale_q10;
         zero_ff   <= (glyph_width == 11'd0) || (glyph_height == 11'd0);
      end
   end

endmodule

// ===== sv/sap_back.sv =====
`timescale 1ns / 1ps
module sap_back
   import sap_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  cfg_type      cfg,
   input  logic         q_valid,
   input  q_item_type   q_head,
   output logic         pop,
   output logic         out_valid,
   input  logic         out_ready,
   output rsp_item_type out_item
);

   typedef enum logic [0:0] {
      ST_IDLE,
      ST_SCAN
   } state_type;

   state_type            state_ff;
   q_item_type           work_ff;
   logic [IDX_W-1:0]     scan_ff;
   logic [COUNT_W-1:0]   count_ff;
   logic [12:0]          cursor_ff [MAX_ATLASES];
   logic [12:0]          top_ff    [MAX_ATLASES];
   logic [12:0]          bottom_ff [MAX_ATLASES];
   logic                 out_valid_ff, out_valid_in;
   rsp_item_type         out_ff, out_in;

   logic [12:0]          cur_x;
   logic [12:0]          cur_top;
   logic [12:0]          cur_bot;
   logic [13:0]          x_end;
   logic                 wrap;
   logic [13:0]          y0;
   logic [14:0]          y_end;
   logic                 fits;
   logic [12:0]          new_x;
   logic [12:0]          new_y;
   logic [13:0]          bot;
   logic                 out_free;
   logic                 last;
   logic                 finish;
   logic                 can_open;
   logic [IDX_W-1:0]     open_idx;
   logic [IDX_W+2:0]     scan_wide;
   logic [IDX_W+2:0]     open_wide;

   assign out_valid = out_valid_ff;
   assign out_item  = out_ff;
   assign out_free  = !out_valid_ff || out_ready;
   assign pop       = (state_ff == ST_IDLE) && q_valid;

   always_comb begin
      cur_x     = cursor_ff[scan_ff];
      cur_top   = top_ff[scan_ff];
      cur_bot   = bottom_ff[scan_ff];
      x_end     = {1'b0, cur_x} + {1'b0, work_ff.wp};
      wrap      = x_end >= {1'b0, cfg.width};
      y0        = wrap ? ({1'b0, cur_bot} + {11'd0, cfg.pad}) : {1'b0, cur_top};
      y_end     = {1'b0, y0} + {2'b0, work_ff.hp};
      fits      = y_end < {2'b0, cfg.height};
      new_x     = wrap ? {10'd0, cfg.pad} : cur_x;
      new_y     = y0[12:0];
      bot       = {1'b0, new_y} + {1'b0, work_ff.hp};
      last      = (COUNT_W'(scan_ff) + COUNT_W'(1)) == count_ff;
      can_open  = count_ff < COUNT_W'(MAX_ATLASES);
      open_idx  = count_ff[IDX_W-1:0];
      scan_wide = {3'd0, scan_ff};
      open_wide = {3'd0, open_idx};
      finish    = (state_ff == ST_SCAN) && (work_ff.zero || fits || last) && out_free;
      out_valid_in = finish || (out_valid_ff && !out_ready);
      out_in    = '0;
      out_in.sw = work_ff.sw;
      out_in.sh = work_ff.sh;
      priority if (work_ff.zero) begin
      end else if (fits) begin
         out_in.placed      = 1'b1;
         out_in.atlas_index = scan_wide[2:0];
         out_in.pos_x       = sat12(new_x);
         out_in.pos_y       = sat12(new_y);
      end else if (can_open) begin
         out_in.placed      = 1'b1;
         out_in.atlas_index = open_wide[2:0];
         out_in.opened      = 1'b1;
      end else begin
         out_in.full = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
         count_ff     <= COUNT_W'(1);
         scan_ff      <= '0;
         for (int i = 0; i < MAX_ATLASES; i++) begin
            cursor_ff[i] <= '0;
            top_ff[i]    <= '0;
            bottom_ff[i] <= '0;
         end
      end else begin
         out_valid_ff <= out_valid_in;
         unique case (state_ff)
            ST_IDLE: begin
               if (q_valid) begin
                  work_ff  <= q_head;
                  scan_ff  <= '0;
                  state_ff <= ST_SCAN;
               end
            end
            ST_SCAN: begin
               if (work_ff.zero || fits || last) begin
                  if (out_free) begin
                     state_ff <= ST_IDLE;
                     out_ff   <= out_in;
                     if (!work_ff.zero) begin
                        if (fits) begin
                           cursor_ff[scan_ff] <= new_x + work_ff.wp;
                           top_ff[scan_ff]    <= new_y;
                           if (bot > {1'b0, cur_bot}) begin
                              bottom_ff[scan_ff] <= bot[12:0];
                           end
                        end else if (can_open) begin
                           cursor_ff[open_idx] <= work_ff.wp;
                           top_ff[open_idx]    <= '0;
                           bottom_ff[open_idx] <= work_ff.hp;
                           count_ff            <= count_ff + COUNT_W'(1);
                        end
                     end
                  end
               end else begin
                  scan_ff <= scan_ff + IDX_W'(1);
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule

// ===== verif/atlas_placement_check.sv =====
`timescale 1ns / 1ps
module atlas_placement_check
   import sap_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [39:0] req_tdata,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [55:0] rsp_tdata,
   input  logic        csr_wen,
   input  logic [1:0]  csr_addr,
   input  logic [12:0] csr_wdata,
   output int          fail_count,
   output int          glyphs_in_flight,
   output int          glyphs_seen,
   output int          placed_n,
   output int          opened_n,
   output int          full_n
);

   logic [12:0]  shape_w;
   logic [12:0]  shape_h;
   logic [2:0]   shape_pad;
   int unsigned  open_count;
   logic [12:0]  shelf_x     [MAX_ATLASES];
   logic [12:0]  shelf_top   [MAX_ATLASES];
   logic [12:0]  shelf_floor [MAX_ATLASES];

   rsp_item_type placements_due [$];
   rsp_item_type want;
   rsp_item_type got;

   function automatic int unsigned scaled_len(input logic [10:0] len, input logic [15:0] sc);
      int unsigned v;
      v = (32'(len) * 32'(sc) + 1023) >> 10;
      return (v > 4095) ? 4095 : v;
   endfunction

   // row packing across the open atlases; updates the shelf state
   function automatic rsp_item_type place_glyph(input logic [10:0] gw, input logic [10:0] gh,
                                                input logic [15:0] sc);
      rsp_item_type r;
      int unsigned  sw, sh, wp, hp, x, y0, bot, slot, i;
      bit           hit;
      r    = '0;
      sw   = scaled_len(gw, sc);
      sh   = scaled_len(gh, sc);
      wp   = sw + 2 * shape_pad;
      hp   = sh + 2 * shape_pad;
      r.sw = sw[11:0];
      r.sh = sh[11:0];
      hit  = 0;
      slot = 0;
      if (gw != 0 && gh != 0) begin
         for (i = 0; i < open_count && !hit; i++) begin
            x  = shelf_x[i];
            y0 = shelf_top[i];
            if (x + wp >= shape_w) begin
               y0 = shelf_floor[i] + shape_pad;
               x  = shape_pad;
            end
            if (y0 + hp < shape_h) begin
               shelf_x[i]   = x[12:0];
               shelf_top[i] = y0[12:0];
               slot         = i;
               hit          = 1;
            end
         end
         if (!hit && open_count < MAX_ATLASES) begin
            slot              = open_count;
            shelf_x[slot]     = '0;
            shelf_top[slot]   = '0;
            shelf_floor[slot] = '0;
            open_count++;
            r.opened = 1;
            hit      = 1;
         end
         if (hit) begin
            x             = shelf_x[slot];
            y0            = shelf_top[slot];
            r.placed      = 1;
            r.atlas_index = slot[2:0];
            r.pos_x       = (x > 4095) ? 12'hFFF : x[11:0];
            r.pos_y       = (y0 > 4095) ? 12'hFFF : y0[11:0];
            shelf_x[slot] = 13'(x + wp);
            bot           = y0 + hp;
            if (bot > shelf_floor[slot])
               shelf_floor[slot] = bot[12:0];
         end else begin
            r.full = 1;
         end
      end
      return r;
   endfunction

   task automatic check_field(input string name, input int unsigned exp_v, input int unsigned act_v);
      if (exp_v != act_v) begin
         $error("%s: expected %0d, got %0d", name, exp_v, act_v);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         shape_w    = RST_ATLAS_WIDTH;
         shape_h    = RST_ATLAS_HEIGHT;
         shape_pad  = RST_PAD_PIXELS;
         open_count = 1;
         foreach (shelf_x[k]) begin
            shelf_x[k]     = '0;
            shelf_top[k]   = '0;
            shelf_floor[k] = '0;
         end
         placements_due.delete();
         fail_count  = 0;
         glyphs_seen = 0;
         placed_n    = 0;
         opened_n    = 0;
         full_n      = 0;
      end else begin
         if (csr_wen) begin
            case (csr_addr)
               CSR_ATLAS_WIDTH:  shape_w   = csr_wdata;
               CSR_ATLAS_HEIGHT: shape_h   = csr_wdata;
               CSR_PAD_PIXELS:   shape_pad = csr_wdata[2:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready)
            placements_due.push_back(place_glyph(req_tdata[10:0], req_tdata[21:11],
                                                 req_tdata[37:22]));
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[53:0];
            if (placements_due.size() == 0) begin
               $error("result item with no request outstanding");
               fail_count++;
            end else begin
               want = placements_due.pop_front();
               check_field("placed",        want.placed,      got.placed);
               check_field("atlas_index",   want.atlas_index, got.atlas_index);
               check_field("pos_x",         want.pos_x,       got.pos_x);
               check_field("pos_y",         want.pos_y,       got.pos_y);
               check_field("scaled_width",  want.sw,          got.sw);
               check_field("scaled_height", want.sh,          got.sh);
               check_field("opened_atlas",  want.opened,      got.opened);
               check_field("atlases_full",  want.full,       got.full);
               check_field("tdata padding", 0,                rsp_tdata[55:54]);
               glyphs_seen++;
               placed_n += want.placed;
               opened_n += want.opened;
               full_n   += want.full;
            end
         end
      end
      glyphs_in_flight = placements_due.size();
   end

endmodule

// ===== verif/shelf_atlas_packer_test.sv =====
`timescale 1ns / 1ps
module shelf_atlas_packer_test;
   import sap_pkg::*;

   logic        clock      = 0;
   logic        reset      = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [39:0] req_tdata  = '0;   // glyph_width, glyph_height, scale_q10
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [55:0] rsp_tdata;         // placed, atlas_index, pos_x, pos_y, scaled_width,
                                   // scaled_height, opened_atlas, atlases_full
   logic        csr_wen    = 0;
   logic [1:0]  csr_addr   = '0;
   logic [12:0] csr_wdata  = '0;

   int fail_count, glyphs_in_flight, glyphs_seen, placed_n, opened_n, full_n;
   bit steady    = 0;
   int hold_asks = 0;
   int shapes    = 1;

   logic [12:0] shape_w   [0:6] = '{13'd4096, 13'd16, 13'd8191, 13'd0, 13'd2048, 13'd8191, 13'd1000};
   logic [12:0] shape_h   [0:6] = '{13'd4096, 13'd16, 13'd8191, 13'd0, 13'd8191, 13'd4096, 13'd600};
   logic [2:0]  shape_pad [0:6] = '{3'd0, 3'd7, 3'd3, 3'd5, 3'd7, 3'd2, 3'd1};

   shelf_atlas_packer dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wen    (csr_wen),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   atlas_placement_check check (
      .clock            (clock),
      .reset            (reset),
      .req_tvalid       (req_tvalid),
      .req_tready       (req_tready),
      .req_tdata        (req_tdata),
      .rsp_tvalid       (rsp_tvalid),
      .rsp_tready       (rsp_tready),
      .rsp_tdata        (rsp_tdata),
      .csr_wen          (csr_wen),
      .csr_addr         (csr_addr),
      .csr_wdata        (csr_wdata),
      .fail_count       (fail_count),
      .glyphs_in_flight (glyphs_in_flight),
      .glyphs_seen      (glyphs_seen),
      .placed_n         (placed_n),
      .opened_n         (opened_n),
      .full_n           (full_n)
   );

   always begin
      #6 clock = 1;
      #6 clock = 0;
   end

   // offer one glyph, wait for the handshake, then maybe go quiet for a while
   task automatic offer_glyph(input logic [10:0] gw, input logic [10:0] gh, input logic [15:0] sc);
      req_tvalid <= 1;
      req_tdata  <= {2'b00, sc, gh, gw};
      do @(posedge clock); while (!req_tready);
      if (!steady && $urandom_range(99) < 31) begin
         req_tvalid <= 0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
   endtask

   task automatic offer_random_glyph();
      int kind;
      kind = $urandom_range(99);
      if (kind < 6) begin
         if ($urandom_range(1))
            offer_glyph(11'd0, 11'($urandom_range(2047)), 16'($urandom_range(65535)));
         else
            offer_glyph(11'($urandom_range(2047)), 11'd0, 16'($urandom_range(65535)));
      end else if (kind < 14) begin
         offer_glyph(11'($urandom_range(2047)), 11'($urandom_range(2047)),
                     16'($urandom_range(65535)));
      end else if (kind < 20) begin
         offer_glyph(11'($urandom_range(1, 48)), 11'($urandom_range(1, 48)),
                     16'($urandom_range(65535)));
      end else begin
         offer_glyph(11'($urandom_range(1, 48)), 11'($urandom_range(1, 48)),
                     16'($urandom_range(256, 2048)));
      end
   endtask

   // drain: all results back, then allow the back end to go quiet
   task automatic settle();
      req_tvalid <= 0;
      do @(negedge clock); while (glyphs_in_flight != 0);
      repeat (16) @(posedge clock);
   endtask

   task automatic set_shape(input logic [12:0] w, input logic [12:0] h, input logic [2:0] pad);
      csr_wen   <= 1;
      csr_addr  <= CSR_ATLAS_WIDTH;
      csr_wdata <= w;
      @(posedge clock);
      csr_addr  <= CSR_ATLAS_HEIGHT;
      csr_wdata <= h;
      @(posedge clock);
      csr_addr  <= CSR_PAD_PIXELS;
      csr_wdata <= 13'(pad);
      @(posedge clock);
      csr_wen   <= 0;
      @(posedge clock);
   endtask

   initial begin : rsp_side
      int hold_left;
      int hold_seen;
      hold_left = 0;
      hold_seen = 0;
      forever begin
         @(posedge clock);
         if (hold_seen != hold_asks) begin
            hold_seen = hold_asks;
            hold_left = 300;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 0;
         end else begin
            rsp_tready <= steady || ($urandom_range(99) >= 31);
         end
      end
   end

   initial begin : stimulus
      int hold_at;
      repeat (12) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // default 512 x 512, one pixel of padding
      offer_glyph(11'd0,    11'd5,    16'd1024);
      offer_glyph(11'd5,    11'd0,    16'd1024);
      offer_glyph(11'd0,    11'd0,    16'hFFFF);
      offer_glyph(11'd10,   11'd10,   16'd0);
      offer_glyph(11'd1,    11'd1,    16'd1);
      offer_glyph(11'd2047, 11'd1,    16'd1);
      offer_glyph(11'd20,   11'd30,   16'd1024);
      offer_glyph(11'd200,  11'd20,   16'd1024);
      offer_glyph(11'd200,  11'd40,   16'd1024);
      offer_glyph(11'd200,  11'd20,   16'd1024);
      offer_glyph(11'd300,  11'd300,  16'd1024);
      offer_glyph(11'd1,    11'd2047, 16'hFFFF);
      // oversized glyphs open atlases at the origin until none is left
      repeat (8) offer_glyph(11'd2047, 11'd2047, 16'hFFFF);
      offer_glyph(11'd3, 11'd3, 16'd1024);
      settle();

      for (int p = 0; p < 7; p++) begin
         set_shape(shape_w[p], shape_h[p], shape_pad[p]);
         shapes++;
         hold_at = $urandom_range(20, 100);
         if (p == 0)
            steady <= 1;
         for (int j = 0; j < 190; j++) begin
            if (p == 0 && j == 150)
               steady <= 0;
            if ((p == 2 || p == 5) && j == hold_at)
               hold_asks <= hold_asks + 1;
            offer_random_glyph();
         end
         settle();
      end

      $display("%0d glyphs checked over %0d atlas shapes: %0d placed, %0d atlases opened,",
               glyphs_seen, shapes, placed_n, opened_n);
      $display("%0d refused with every atlas in use", full_n);
      if (fail_count == 0 && glyphs_in_flight == 0)
         $display("shelf_atlas_packer regression: pass");
      else
         $display("shelf_atlas_packer regression: fail");
      $finish;
   end

   initial begin : watchdog
      #5_000_000;
      $display("shelf_atlas_packer regression: fail");
      $finish;
   end

endmodule
